// ----- rtl/core/dfl_pkg.sv -----
`timescale 1ns / 1ps

package dfl_pkg;

    // field widths fixed by the interface
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned FAULT_W  = 4;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned THR_W    = 56;
    localparam int unsigned THR_STEP = 4;
    localparam int unsigned SAFE_W   = 14;
    localparam int unsigned ACT_W    = 14;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W    = THR_W;

    // register reset values
    localparam logic [THR_W-1:0]  THR_RESET  = 56'd23418572033336659;
    localparam logic [SAFE_W-1:0] SAFE_RESET = 14'd16144;

    // request codes
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLDS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_MASK  = 1'd1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [FAULT_W-1:0] fault_index;
        logic               bad_sample;
        logic [TIME_W-1:0]  time_ms;
    } t_req;

    typedef struct packed {
        logic               event_valid;
        logic [FAULT_W-1:0] event_fault;
        logic               event_raised;
        logic [TIME_W-1:0]  event_time;
        logic [ACT_W-1:0]   active_set;
        logic               enter_safe;
    } t_result;

endpackage

// ----- rtl/core/dfl_in_reg.sv -----
`timescale 1ns / 1ps

module dfl_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dfl_pkg::t_req i_req,
    input  logic          i_advance,
    output logic          o_valid,
    output dfl_pkg::t_req o_req
);
    import dfl_pkg::*;

    logic r_valid;
    t_req r_req;

    // free when empty or when the held beat moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ----- rtl/core/dfl_engine.sv -----
`timescale 1ns / 1ps

module dfl_engine #(
    parameter int unsigned NUM_FAULTS = 14,
    parameter int unsigned COUNT_BITS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  dfl_pkg::t_req                i_req,
    input  logic [dfl_pkg::THR_W-1:0]    i_thresholds,
    input  logic [dfl_pkg::SAFE_W-1:0]   i_safe_mask,
    output dfl_pkg::t_result             o_result
);
    import dfl_pkg::*;

    logic [COUNT_BITS-1:0] r_streak [NUM_FAULTS];
    logic [COUNT_BITS-1:0] n_streak [NUM_FAULTS];
    logic [NUM_FAULTS-1:0] r_latch;
    logic [NUM_FAULTS-1:0] n_latch;
    logic [NUM_FAULTS-1:0] set_ev;
    logic [NUM_FAULTS-1:0] clr_ev;
    logic [ACT_W-1:0]      active;
    logic                  any_ev;

    wire is_update = (i_req.req_type == REQ_UPDATE);
    wire is_set    = (i_req.req_type == REQ_SET);
    wire is_clear  = (i_req.req_type == REQ_CLEAR);

    // one lane per fault, only the addressed lane can change
    for (genvar f = 0; f < NUM_FAULTS; f++) begin : g_lane
        logic [COUNT_BITS-1:0] thr;
        logic                  hit;
        logic                  want_set;

        // faults beyond the packed register get a zero threshold
        if (f * THR_STEP < THR_W) begin : g_thr
            assign thr = i_thresholds[f*THR_STEP +: COUNT_BITS];
        end else begin : g_no_thr
            assign thr = '0;
        end

        assign hit = (i_req.fault_index == FAULT_W'(f));

        always_comb begin
            n_streak[f] = r_streak[f];
            if (hit && is_update) begin
                if (!i_req.bad_sample) begin
                    n_streak[f] = '0;
                end else if (r_streak[f] < thr) begin
                    n_streak[f] = r_streak[f] + COUNT_BITS'(1);
                end
            end
        end

        assign want_set = hit && ((is_update && i_req.bad_sample && (n_streak[f] >= thr))
                                  || is_set);
        assign set_ev[f]  = want_set && !r_latch[f];
        assign clr_ev[f]  = hit && is_clear && r_latch[f];
        assign n_latch[f] = r_latch[f] ^ (set_ev[f] | clr_ev[f]);
    end

    // fit the latch vector to the result width
    for (genvar i = 0; i < ACT_W; i++) begin : g_act
        if (i < NUM_FAULTS) begin : g_bit
            assign active[i] = n_latch[i];
        end else begin : g_pad
            assign active[i] = 1'b0;
        end
    end

    assign any_ev = |(set_ev | clr_ev);

    always_comb begin
        o_result.event_valid  = any_ev;
        o_result.event_fault  = any_ev ? i_req.fault_index : '0;
        o_result.event_raised = |set_ev;
        o_result.event_time   = any_ev ? i_req.time_ms : '0;
        o_result.active_set   = active;
        o_result.enter_safe   = |(active & i_safe_mask);
    end

    // state commits when the beat moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
            for (int k = 0; k < NUM_FAULTS; k++) begin
                r_streak[k] <= '0;
            end
        end else if (i_advance) begin
            r_latch <= n_latch;
            for (int k = 0; k < NUM_FAULTS; k++) begin
                r_streak[k] <= n_streak[k];
            end
        end
    end

endmodule

// ----- rtl/core/dfl_out_reg.sv -----
`timescale 1ns / 1ps

module dfl_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  dfl_pkg::t_result i_result,
    output logic             o_advance,
    output logic             o_valid,
    input  logic             i_ready,
    output dfl_pkg::t_result o_result
);
    import dfl_pkg::*;

    logic    r_valid;
    t_result r_result;

    // load when empty or when the held result is taken
    assign o_advance = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/core/debounced_fault_latch.sv -----
`timescale 1ns / 1ps

// channel | direction | handshake                 | payload
// request | in        | i_in_valid / o_in_ready   | req_type, fault_index, bad_sample, time_ms
// result  | out       | o_out_valid / i_out_ready | event_*, active_set, enter_safe
// config  | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// one request per cycle sustained while results are taken; a result passes the input register,
// then the counter/latch update into the result register.
// synchronous active-low reset clears counters, latches and valids, and loads the
// config registers with their reset values.
// a stalled result holds the result register; the input register then fills and
// o_in_ready drops until the result beat is taken.

module debounced_fault_latch #(
    parameter int unsigned NUM_FAULTS = 14,
    parameter int unsigned COUNT_BITS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [dfl_pkg::REQ_W-1:0]       i_req_type,
    input  logic [dfl_pkg::FAULT_W-1:0]     i_fault_index,
    input  logic                            i_bad_sample,
    input  logic [dfl_pkg::TIME_W-1:0]      i_time_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_event_valid,
    output logic [dfl_pkg::FAULT_W-1:0]     o_event_fault,
    output logic                            o_event_raised,
    output logic [dfl_pkg::TIME_W-1:0]      o_event_time,
    output logic [dfl_pkg::ACT_W-1:0]       o_active_set,
    output logic                            o_enter_safe,
    input  logic                            i_cfg_we,
    input  logic [dfl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dfl_pkg::CFG_W-1:0]       i_cfg_data
);
    import dfl_pkg::*;

    logic [THR_W-1:0]  r_thresholds;
    logic [SAFE_W-1:0] r_safe_mask;
    t_req              in_req;
    t_req              held_req;
    t_result           eng_result;
    t_result           out_result;
    logic              held_valid;
    logic              advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresholds <= THR_RESET;
            r_safe_mask  <= SAFE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLDS: r_thresholds <= i_cfg_data[THR_W-1:0];
                CFG_SAFE_MASK:  r_safe_mask  <= i_cfg_data[SAFE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        in_req.req_type    = i_req_type;
        in_req.fault_index = i_fault_index;
        in_req.bad_sample  = i_bad_sample;
        in_req.time_ms     = i_time_ms;
    end

    dfl_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_req     (in_req),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_req     (held_req)
    );

    dfl_engine #(
        .NUM_FAULTS (NUM_FAULTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_req        (held_req),
        .i_thresholds (r_thresholds),
        .i_safe_mask  (r_safe_mask),
        .o_result     (eng_result)
    );

    dfl_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (held_valid),
        .i_result  (eng_result),
        .o_advance (advance),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_result  (out_result)
    );

    assign o_event_valid  = out_result.event_valid;
    assign o_event_fault  = out_result.event_fault;
    assign o_event_raised = out_result.event_raised;
    assign o_event_time   = out_result.event_time;
    assign o_active_set   = out_result.active_set;
    assign o_enter_safe   = out_result.enter_safe;

endmodule
